// ===== rtl/rfcrc_pkg.sv =====
// Shared constants and types for the framed range parser with CRC-8 check.
// No dependencies; imported by the top level and the port checker.
package rfcrc_pkg;

    localparam int RANGE_COUNT = 8;
    localparam int FRAME_BYTES = 19;

    localparam int CNT_W    = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W    = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;
    localparam int RAW_W    = 16;
    localparam int DIST_W   = 17;
    localparam int OFFSET_W = 10;
    localparam int HDR_W    = 8;
    localparam int CFG_W    = 10;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(60);
    localparam logic [HDR_W-1:0]    HEADER_RESET = HDR_W'(84);

    // Register indexes on the configuration port
    localparam logic CFG_OFFSET = 1'b0;
    localparam logic CFG_HEADER = 1'b1;

    typedef enum logic [1:0] {
        ST_RANGE    = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CRC  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

// ===== rtl/range_frame_crc8_parser_top.sv =====
// Framed range parser with CRC-8 check: top level, one module.
// Depends on rfcrc_pkg.
//
// Takes one serial byte per transaction and assembles frames that open with the
// header byte. The CRC-8 (poly 0x07) is computed one bit per cycle by a single
// shift/xor unit, so a frame byte at positions 0 to FRAME_BYTES-2 keeps the
// input stalled while it is shifted through the unit; the received CRC byte is
// taken without stalling the input. A byte that ends a frame produces either
// RANGE_COUNT range results (one per cycle through a shared adder, while the
// output is not stalled) or one status result; after the last result is taken
// the header is fed through the CRC unit, which stalls the input again while
// it is shifted. The input is stalled whenever a result is pending.
module range_frame_crc8_parser_top
    import rfcrc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // byte input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_rx_byte,
    // result output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic [2:0]                o_range_index,
    output logic signed [DIST_W-1:0]  o_distance_mm,
    output logic                      o_no_target,
    output logic                      o_last
);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [7:0]              r_crc, n_crc;
    logic [7:0]              r_rx_crc, n_rx_crc;
    logic [2:0]              r_bits, n_bits;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [OFFSET_W-1:0]     r_offset;
    logic [HDR_W-1:0]        r_header;
    logic [RAW_W-1:0]        r_range [RANGE_COUNT];

    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic [IDX_W-1:0]        r_out_idx, n_out_idx;
    logic [DIST_W-1:0]       r_dist, n_dist;
    logic                    r_no_tgt, n_no_tgt;
    logic                    r_last, n_last;

    logic                    is_hdr;
    logic                    full;
    logic [IDX_W-1:0]        ld_idx;
    logic [RAW_W-1:0]        ld_raw;
    logic [DIST_W-1:0]       ld_sum;
    logic                    wr_en;
    logic [CNT_W-1:0]        pos_m2;
    logic [CNT_W-2:0]        wr_slot;

    assign is_hdr = (i_rx_byte == r_header);
    assign full   = (r_count >= CNT_W'(FRAME_BYTES));

    // Shared adder: sign-extended raw range plus offset
    assign ld_raw = r_range[ld_idx];
    assign ld_sum = {ld_raw[RAW_W-1], ld_raw} + {{(DIST_W-OFFSET_W){1'b0}}, r_offset};

    // Range byte write position
    assign pos_m2  = r_count - CNT_W'(2);
    assign wr_slot = pos_m2[CNT_W-1:1];
    assign wr_en   = (r_state == S_IDLE) && i_valid && !is_hdr && !full
                     && (r_count >= CNT_W'(2)) && (r_count < CNT_W'(FRAME_BYTES - 1))
                     && (wr_slot < (CNT_W-1)'(RANGE_COUNT));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_crc       = r_crc;
        n_rx_crc    = r_rx_crc;
        n_bits      = r_bits;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_idx   = r_out_idx;
        n_dist      = r_dist;
        n_no_tgt    = r_no_tgt;
        n_last      = r_last;
        ld_idx      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!is_hdr && !full) begin
                        // ordinary frame byte
                        if (r_count < CNT_W'(FRAME_BYTES - 1)) begin
                            n_crc   = r_crc ^ i_rx_byte;
                            n_bits  = 3'd7;
                            n_state = S_CRC;
                        end else if (r_count == CNT_W'(FRAME_BYTES - 1)) begin
                            n_rx_crc = i_rx_byte;
                        end
                        n_count = r_count + CNT_W'(1);
                    end else if (is_hdr && full && (r_crc == r_rx_crc)) begin
                        // start the range burst at sensor 0
                        ld_idx      = '0;
                        n_idx       = '0;
                        n_out_valid = 1'b1;
                        n_status    = ST_RANGE;
                        n_out_idx   = '0;
                        n_no_tgt    = (ld_raw == '0);
                        n_dist      = (ld_raw == '0) ? '0 : ld_sum;
                        n_last      = (RANGE_COUNT == 1);
                        n_state     = S_EMIT;
                    end else begin
                        // single status transaction
                        n_out_valid = 1'b1;
                        priority if (!is_hdr) n_status = ST_OVERFLOW;
                        else if (full)        n_status = ST_CRC_ERR;
                        else                  n_status = ST_SHORT;
                        n_out_idx   = '0;
                        n_no_tgt    = 1'b0;
                        n_dist      = '0;
                        n_last      = 1'b1;
                        n_state     = S_EMIT;
                    end
                end
            end
            S_CRC: begin
                // one CRC bit per cycle
                n_crc = r_crc[7] ? ({r_crc[6:0], 1'b0} ^ CRC_POLY) : {r_crc[6:0], 1'b0};
                if (r_bits == 3'd0) begin
                    n_state = S_IDLE;
                end else begin
                    n_bits = r_bits - 3'd1;
                end
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (r_last) begin
                        // restart the frame with the header as byte 0
                        n_out_valid = 1'b0;
                        n_count     = CNT_W'(1);
                        n_crc       = r_header;
                        n_bits      = 3'd7;
                        n_state     = S_CRC;
                    end else begin
                        // advance to the next sensor
                        ld_idx    = r_idx + IDX_W'(1);
                        n_idx     = ld_idx;
                        n_out_idx = ld_idx;
                        n_no_tgt  = (ld_raw == '0);
                        n_dist    = (ld_raw == '0) ? '0 : ld_sum;
                        n_last    = (ld_idx == IDX_W'(RANGE_COUNT - 1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_crc       <= '0;
            r_bits      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_offset    <= OFFSET_RESET;
            r_header    <= HEADER_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_bits      <= n_bits;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                    CFG_HEADER: r_header <= i_cfg_data[HDR_W-1:0];
                    default:    r_offset <= r_offset;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rx_crc  <= n_rx_crc;
        r_status  <= n_status;
        r_out_idx <= n_out_idx;
        r_dist    <= n_dist;
        r_no_tgt  <= n_no_tgt;
        r_last    <= n_last;
        if (wr_en) begin
            if (!pos_m2[0]) begin
                r_range[wr_slot[IDX_W-1:0]][RAW_W-1:8] <= i_rx_byte;
            end else begin
                r_range[wr_slot[IDX_W-1:0]][7:0] <= i_rx_byte;
            end
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_range_index = 3'(r_out_idx);
    assign o_distance_mm = r_dist;
    assign o_no_target   = r_no_tgt;
    assign o_last        = r_last;

endmodule

// ===== rtl/rfcrc_checker.sv =====
// Port-level checker for the framed range parser, bound to the top level.
// Depends on rfcrc_pkg and range_frame_crc8_parser_top.
module rfcrc_checker
    import rfcrc_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic                      i_cfg_index,
    input logic [CFG_W-1:0]          i_cfg_data,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [7:0]                i_rx_byte,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [1:0]                o_status,
    input logic [2:0]                o_range_index,
    input logic signed [DIST_W-1:0]  o_distance_mm,
    input logic                      o_no_target,
    input logic                      o_last
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_range_index)
            && $stable(o_distance_mm) && $stable(o_no_target) && $stable(o_last))
        else $error("stalled result changed");

    // No byte is taken while a result is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready with result pending");

    // Status transactions are single, final and carry no range
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_RANGE) |-> o_last && (o_range_index == 3'd0)
            && (o_distance_mm == '0) && !o_no_target)
        else $error("malformed status result");

    // No target reads as zero distance
    a_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_target |-> (o_distance_mm == '0))
        else $error("no target with nonzero distance");

    // Range burst advances one sensor per taken transaction
    a_burst_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_status == ST_RANGE) && !o_last |=>
            o_valid && (o_status == ST_RANGE) && (o_range_index == $past(o_range_index) + 3'd1))
        else $error("range burst out of order");

endmodule

bind range_frame_crc8_parser_top rfcrc_checker u_rfcrc_checker (.*);
